// File: hdl/infix_expression_evaluator_unit_assert.svh
// Assertion macros shared by the evaluator RTL.
`ifndef INFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define IEE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define IEE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/iee_pkg.sv
// Package with shared constants and types of the infix expression evaluator.
`default_nettype none

package iee_pkg;

    localparam int IEE_WORD_BITS = 32;
    localparam int VALUE_BITS    = 32;

    // Character codes the scanner recognizes.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Input kind carried in tuser.
    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Request to the shared multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } unit_req_t;

    // Status from the shared multiply/divide unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_rsp_t;

endpackage

`default_nettype wire

// File: hdl/infix_expression_evaluator_unit.sv
// Top level of the streaming four-operator infix expression evaluator.
//
//  Channel | Direction | Ports               | Contents
//  --------+-----------+---------------------+-----------------------------------------
//  s_      | in        | tvalid tready tdata | tdata[7:0] char_code; tuser[0] action
//  m_      | out       | tvalid tready tdata | tdata[31:0] value;    tuser[0] div_by_zero
//
// A digit, a whitespace character, plus, minus or an unknown operator is taken without
// holding off the input, and the next input transaction can follow in the very next cycle.
// An operator that has to apply a pending multiply or divide occupies the shared
// multiply/divide unit, which takes one adder step per cycle, and s_tready stays low
// meanwhile.
// The end marker passes through ST_EMIT to form the result, and stays there while the result
// register is still waiting for m_tready; the input side is held off until then.
// aresetn is synchronous and active low; it clears the expression state and m_tvalid.
`default_nettype none
`include "infix_expression_evaluator_unit_assert.svh"

module infix_expression_evaluator_unit import iee_pkg::*; #(
    parameter int WORD_BITS = IEE_WORD_BITS
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    // Input transactions.
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] char_code
    input  wire logic [0:0]             s_tuser,   // [0] action
    // Result transactions.
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [VALUE_BITS-1:0]       m_tdata,   // [31:0] value
    output logic [0:0]                  m_tuser    // [0] div_by_zero
);

    // Pending operator codes.
    typedef enum logic [2:0] {
        OP_FIRST = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_NONE  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    op_t                  pend_reg, pend_next;
    op_t                  new_op;
    logic                 end_reg, end_next;
    logic                 zdiv_reg, zdiv_next;
    logic [WORD_BITS-1:0] sum_reg, sum_next;
    logic [WORD_BITS-1:0] term_reg, term_next;
    logic [WORD_BITS-1:0] num_reg, num_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [VALUE_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic                 in_fire;
    logic                 out_free;
    logic                 is_end;
    logic                 is_digit;
    logic                 is_space;
    logic [WORD_BITS-1:0] digit_val;
    logic [WORD_BITS-1:0] total;

    unit_req_t            unit_req;
    unit_rsp_t            unit_rsp;
    logic [WORD_BITS-1:0] unit_result;

    iee_muldiv #(
        .WORD_BITS (WORD_BITS)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (unit_req),
        .opnd_a  (term_reg),
        .opnd_b  (num_reg),
        .rsp     (unit_rsp),
        .result  (unit_result)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid & s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Character classes. Anything that is neither a digit nor whitespace acts as an
    // operator, the NUL code included.
    assign is_end    = (s_tuser[0] == ACT_END);
    assign is_digit  = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    assign is_space  = (s_tdata == CHAR_SPACE) || ((s_tdata >= CHAR_TAB) && (s_tdata <= CHAR_CR));
    assign digit_val = WORD_BITS'(s_tdata - CHAR_ZERO);
    assign total     = sum_reg + term_reg;

    always_comb begin
        unique case (s_tdata)
            CHAR_PLUS:  new_op = OP_ADD;
            CHAR_MINUS: new_op = OP_SUB;
            CHAR_STAR:  new_op = OP_MUL;
            CHAR_SLASH: new_op = OP_DIV;
            default:    new_op = OP_NONE;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        end_next      = end_reg;
        zdiv_next     = zdiv_reg;
        sum_next      = sum_reg;
        term_next     = term_reg;
        num_next      = num_reg;
        unit_req      = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (is_end || !(is_digit || is_space)) begin
                        // Close the number just finished under the pending operator.
                        num_next = '0;
                        case (pend_reg)
                            OP_FIRST: term_next = num_reg;
                            OP_ADD: begin
                                sum_next  = sum_reg + term_reg;
                                term_next = num_reg;
                            end
                            OP_SUB: begin
                                sum_next  = sum_reg + term_reg;
                                term_next = -num_reg;
                            end
                            OP_MUL: begin
                                unit_req.start = 1'b1;
                                state_next     = ST_BUSY;
                            end
                            OP_DIV: begin
                                // A zero divisor leaves the term alone and only flags.
                                if (num_reg == '0) begin
                                    zdiv_next = 1'b1;
                                end else begin
                                    unit_req.start  = 1'b1;
                                    unit_req.is_div = 1'b1;
                                    state_next      = ST_BUSY;
                                end
                            end
                            default: ;
                        endcase
                        if (is_end) begin
                            end_next = 1'b1;
                            if (!unit_req.start) begin
                                state_next = ST_EMIT;
                            end
                        end else begin
                            pend_next = new_op;
                        end
                    end else if (is_digit) begin
                        num_next = (num_reg << 3) + (num_reg << 1) + digit_val;
                    end
                end
            end
            ST_BUSY: begin
                if (unit_rsp.done) begin
                    term_next  = unit_result;
                    state_next = end_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = VALUE_BITS'(signed'(total));
                    m_tuser_next  = zdiv_reg;
                    // Back to the state of a fresh expression.
                    sum_next   = '0;
                    term_next  = '0;
                    num_next   = '0;
                    pend_next  = OP_FIRST;
                    zdiv_next  = 1'b0;
                    end_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_reg     <= OP_FIRST;
            end_reg      <= 1'b0;
            zdiv_reg     <= 1'b0;
            sum_reg      <= '0;
            term_reg     <= '0;
            num_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            end_reg      <= end_next;
            zdiv_reg     <= zdiv_next;
            sum_reg      <= sum_next;
            term_reg     <= term_next;
            num_reg      <= num_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // The input side is only open while the shared unit is free.
    `IEE_ASSERT_NOW(a_ready_unit_free, aclk, aresetn, s_tready, !unit_rsp.busy, "input accepted while unit busy")
    // A unit completion is only expected while the sequencer waits for it.
    `IEE_ASSERT_NOW(a_done_in_busy, aclk, aresetn, unit_rsp.done, state_reg == ST_BUSY, "unit done outside busy state")
    // Emitting a result presents it and returns the block to a fresh expression.
    `IEE_ASSERT_NEXT(a_emit_clears, aclk, aresetn, (state_reg == ST_EMIT) && out_free, m_tvalid && (state_reg == ST_IDLE) && (pend_reg == OP_FIRST) && (sum_reg == '0), "emit did not present result or clear state")

endmodule

`default_nettype wire

// File: hdl/iee_muldiv.sv
// Iterative multiply and signed truncating divide around one shared adder.
`default_nettype none

module iee_muldiv import iee_pkg::*; #(
    parameter int WORD_BITS = IEE_WORD_BITS
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire unit_req_t             req,
    input  wire logic [WORD_BITS-1:0]  opnd_a,
    input  wire logic [WORD_BITS-1:0]  opnd_b,
    output unit_rsp_t                  rsp,
    output logic [WORD_BITS-1:0]       result
);

    localparam int CNT_W = $clog2(WORD_BITS);

    logic                 run_reg;
    logic                 fin_reg;
    logic                 done_reg;
    logic                 div_reg;
    logic                 neg_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [WORD_BITS:0]   acc_reg;
    logic [WORD_BITS-1:0] opa_reg;
    logic [WORD_BITS-1:0] opb_reg;
    logic [WORD_BITS-1:0] result_reg;

    logic [WORD_BITS-1:0] mag_a;
    logic [WORD_BITS-1:0] mag_b;
    logic [WORD_BITS:0]   shift_rem;
    logic [WORD_BITS:0]   add_x;
    logic [WORD_BITS:0]   add_y;
    logic                 add_cin;
    logic [WORD_BITS+1:0] add_sum;
    logic                 fits;

    // Operand magnitudes for the divide; the sign is restored at the end.
    assign mag_a = opnd_a[WORD_BITS-1] ? -opnd_a : opnd_a;
    assign mag_b = opnd_b[WORD_BITS-1] ? -opnd_b : opnd_b;

    assign shift_rem = {acc_reg[WORD_BITS-1:0], opb_reg[WORD_BITS-1]};

    // The one adder: trial subtract for division, accumulate for multiply.
    always_comb begin
        if (div_reg) begin
            add_x   = shift_rem;
            add_y   = ~{1'b0, opa_reg};
            add_cin = 1'b1;
        end else begin
            add_x   = {1'b0, acc_reg[WORD_BITS-1:0]};
            add_y   = opb_reg[0] ? {1'b0, opa_reg} : '0;
            add_cin = 1'b0;
        end
        add_sum = {1'b0, add_x} + {1'b0, add_y} + (WORD_BITS+2)'(add_cin);
        fits    = add_sum[WORD_BITS+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg <= 1'b1;
            end else if (run_reg) begin
                if (cnt_reg == '0) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            div_reg <= req.is_div;
            neg_reg <= opnd_a[WORD_BITS-1] ^ opnd_b[WORD_BITS-1];
            cnt_reg <= CNT_W'(WORD_BITS - 1);
            acc_reg <= '0;
            opa_reg <= req.is_div ? mag_b : opnd_a;
            opb_reg <= req.is_div ? mag_a : opnd_b;
        end else if (run_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (div_reg) begin
                // Restoring step: dividend bits leave at the top of opb,
                // quotient bits enter at the bottom.
                acc_reg <= fits ? add_sum[WORD_BITS:0] : shift_rem;
                opb_reg <= {opb_reg[WORD_BITS-2:0], fits};
            end else begin
                acc_reg <= add_sum[WORD_BITS:0];
                opa_reg <= opa_reg << 1;
                opb_reg <= opb_reg >> 1;
            end
        end else if (fin_reg) begin
            if (div_reg) begin
                result_reg <= neg_reg ? -opb_reg : opb_reg;
            end else begin
                result_reg <= acc_reg[WORD_BITS-1:0];
            end
        end
    end

    assign rsp.busy = run_reg | fin_reg;
    assign rsp.done = done_reg;
    assign result   = result_reg;

endmodule

`default_nettype wire

// File: dv/expression_result_checker.sv
// Passive checker for the infix expression evaluator: it predicts each result and compares.
module expression_result_checker import iee_pkg::*; #(
    parameter int W = IEE_WORD_BITS
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    input  wire                   s_tready,
    input  wire [7:0]             s_tdata,
    input  wire [0:0]             s_tuser,
    input  wire                   m_tvalid,
    input  wire                   m_tready,
    input  wire [VALUE_BITS-1:0]  m_tdata,
    input  wire [0:0]             m_tuser,
    output int                    error_count,
    output int                    pending_count
);

    typedef enum logic [2:0] {
        PEND_FIRST,
        PEND_ADD,
        PEND_SUB,
        PEND_MUL,
        PEND_DIV,
        PEND_NONE
    } pend_op_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  div_by_zero;
    } expr_result_t;

    logic [W-1:0]  sum_acc;
    logic [W-1:0]  term_acc;
    logic [W-1:0]  number_acc;
    pend_op_t      pend_op;
    logic          zero_div_seen;
    expr_result_t  awaited_results[$];
    expr_result_t  oldest;

    initial begin
        error_count   = 0;
        pending_count = 0;
    end

    // Signed division that truncates toward zero; the most negative word divided by
    // minus one wraps back to itself.
    function automatic logic [W-1:0] signed_quotient(input logic [W-1:0] a,
                                                     input logic [W-1:0] b);
        logic         a_neg;
        logic         b_neg;
        logic [W-1:0] a_mag;
        logic [W-1:0] b_mag;
        logic [W-1:0] q;
        a_neg = a[W-1];
        b_neg = b[W-1];
        a_mag = a_neg ? -a : a;
        b_mag = b_neg ? -b : b;
        q     = a_mag / b_mag;
        return (a_neg != b_neg) ? -q : q;
    endfunction

    task clear_expression();
        sum_acc       = '0;
        term_acc      = '0;
        number_acc    = '0;
        pend_op       = PEND_FIRST;
        zero_div_seen = 1'b0;
    endtask

    // Folds the finished number into the term or the sum under the pending operator.
    task close_number();
        case (pend_op)
            PEND_FIRST: term_acc = number_acc;
            PEND_ADD: begin
                sum_acc  = sum_acc + term_acc;
                term_acc = number_acc;
            end
            PEND_SUB: begin
                sum_acc  = sum_acc + term_acc;
                term_acc = -number_acc;
            end
            PEND_MUL: term_acc = term_acc * number_acc;
            PEND_DIV: begin
                if (number_acc == '0) begin
                    zero_div_seen = 1'b1;
                end else begin
                    term_acc = signed_quotient(term_acc, number_acc);
                end
            end
            default: ;
        endcase
        number_acc = '0;
    endtask

    task take_character(input logic act, input logic [7:0] c);
        logic [W-1:0]  total;
        expr_result_t  res;
        if (act == ACT_END) begin
            close_number();
            total           = sum_acc + term_acc;
            res.value       = VALUE_BITS'($signed(total));
            res.div_by_zero = zero_div_seen;
            awaited_results = {awaited_results, res};
            clear_expression();
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            number_acc = number_acc * 10 + W'(c - CHAR_ZERO);
        end else if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
            // Whitespace leaves the expression untouched.
        end else begin
            close_number();
            case (c)
                CHAR_PLUS:  pend_op = PEND_ADD;
                CHAR_MINUS: pend_op = PEND_SUB;
                CHAR_STAR:  pend_op = PEND_MUL;
                CHAR_SLASH: pend_op = PEND_DIV;
                default:    pend_op = PEND_NONE;
            endcase
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_expression();
            awaited_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                take_character(s_tuser[0], s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transaction with no expression pending: value %0d",
                           $signed(m_tdata));
                    error_count++;
                end else begin
                    oldest = awaited_results.pop_front();
                    if (m_tdata !== oldest.value) begin
                        $error("value mismatch: expected %0d, actual %0d",
                               $signed(oldest.value), $signed(m_tdata));
                        error_count++;
                    end
                    if (m_tuser[0] !== oldest.div_by_zero) begin
                        $error("div_by_zero mismatch: expected %0b, actual %0b",
                               oldest.div_by_zero, m_tuser[0]);
                        error_count++;
                    end
                end
            end
        end
        pending_count = awaited_results.size();
    end

endmodule

// File: dv/tb_infix_expression_evaluator_unit.sv
// Testbench top of the infix expression evaluator: clock, reset, stimulus and verdict.
module tb_infix_expression_evaluator_unit import iee_pkg::*; ();

    // Codes used as unknown operators in the directed expressions.
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_TOP = 8'hFF;

    // Number of cycles the receiver refuses results during the back-pressure test.
    localparam int LONG_STALL_CYCLES = 600;
    // Non-whitespace input transactions sent in each random phase.
    localparam int PHASE_ITEMS = 390;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = '0;
    logic [0:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [VALUE_BITS-1:0]  m_tdata;
    logic [0:0]             m_tuser;

    int error_count;
    int pending_count;

    // Idle percentages of the two sides, changed from phase to phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit long_stall_req = 1'b0;
    // Non-whitespace input transactions accepted so far.
    int sent_items     = 0;

    always #1 aclk = ~aclk;

    infix_expression_evaluator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    expression_result_checker result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    function automatic bit is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(3))
            0:       return CHAR_PLUS;
            1:       return CHAR_MINUS;
            2:       return CHAR_STAR;
            default: return CHAR_SLASH;
        endcase
    endfunction

    // Any code that is neither a digit, whitespace nor one of the four operators.
    function automatic logic [7:0] odd_symbol();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (is_blank(c) || (c >= CHAR_ZERO && c <= CHAR_NINE) ||
                   c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR || c == CHAR_SLASH);
        return c;
    endfunction

    // Offers one input transaction and returns at the edge that accepts it. The sender
    // may first sit idle for a random number of cycles; tvalid stays high from one
    // transaction to the next when no idle cycle is drawn.
    task automatic push(input logic act, input logic [7:0] code);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= code;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!(act == ACT_CHAR && is_blank(code))) sent_items++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) push(ACT_CHAR, text[i]);
    endtask

    task automatic maybe_blank();
        if ($urandom_range(99) < 12) begin
            if ($urandom_range(1) == 0) push(ACT_CHAR, CHAR_SPACE);
            else push(ACT_CHAR, 8'($urandom_range(CHAR_CR, CHAR_TAB)));
        end
    endtask

    // Numbers are mostly short; a few are long enough to wrap, and some are the words
    // that read as the most negative value and as minus one once wrapped.
    task automatic send_number();
        int kind;
        int digits;
        kind = $urandom_range(99);
        if (kind < 5) begin
            send_text("4294967295");
        end else if (kind < 9) begin
            send_text("2147483648");
        end else if (kind < 20) begin
            push(ACT_CHAR, CHAR_ZERO);
        end else begin
            digits = (kind < 30) ? $urandom_range(11, 5) : $urandom_range(3, 1);
            for (int i = 0; i < digits; i++) push(ACT_CHAR, CHAR_ZERO + 8'($urandom_range(9)));
        end
    endtask

    // One random expression closed by an end marker. Most are well formed; a share
    // starts or ends with an operator, misses a number, carries an unknown operator
    // or stray bytes, and a few are empty.
    task automatic send_expression();
        int shape;
        int terms;
        shape = $urandom_range(99);
        if (shape >= 4) begin
            terms = $urandom_range(6, 1);
            if (shape < 12) push(ACT_CHAR, random_operator());
            for (int t = 0; t < terms; t++) begin
                maybe_blank();
                if ($urandom_range(99) >= 4) send_number();
                maybe_blank();
                if ($urandom_range(99) < 3) push(ACT_CHAR, 8'($urandom_range(255)));
                if (t < terms - 1) begin
                    if ($urandom_range(99) < 8) push(ACT_CHAR, odd_symbol());
                    else push(ACT_CHAR, random_operator());
                end
            end
            if (shape >= 95) push(ACT_CHAR, random_operator());
        end
        // The end marker ignores its character, so it carries a random one.
        push(ACT_END, 8'($urandom_range(255)));
    endtask

    // Result side: random stalls at the phase's rate, and one long hold-off on request,
    // counted here so that the sender keeps offering transactions meanwhile.
    initial begin
        forever begin
            @(posedge aclk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hard limit on the run, many times the slowest correct run.
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed expressions. An empty expression gives zero.
        push(ACT_END, CHAR_TOP);
        // A leading minus makes the most negative word, and the divisor wraps to minus
        // one, so the quotient wraps back to the most negative word.
        send_text("-2147483648/4294967295");
        push(ACT_END, CHAR_NUL);
        // Whitespace is skipped, an unknown operator throws away the three, and the
        // division by zero keeps the term at seven and raises the flag.
        send_text("\t7 %3/0");
        push(ACT_END, CHAR_ZERO);
        // Leading plus counts the empty first number as zero; the NUL code and the
        // all-ones code act as unknown operators that discard the numbers after them.
        send_text("+6*5");
        push(ACT_CHAR, CHAR_NUL);
        push(ACT_CHAR, CHAR_NINE);
        push(ACT_CHAR, CHAR_TOP);
        push(ACT_END, CHAR_SPACE);

        // Long receiver hold-off while the sender streams without a gap, so that the
        // result register fills and the end marker behind it stalls the input.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_stall_req = 1'b1;
        repeat (6) send_expression();

        // Random phases with different idle patterns on the two sides.
        for (int phase = 0; phase < 4; phase++) begin
            int target;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            target = sent_items + PHASE_ITEMS;
            while (sent_items < target) send_expression();
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then give the block time to misbehave.
        while (pending_count != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
